// ===== rtl/gcn_pkg.sv =====
// Shared constants, opcodes and state encoding for the graph convolution layer.
package gcn_pkg;

  localparam int unsigned NODES     = 1024;
  localparam int unsigned IN_WIDTH  = 64;
  localparam int unsigned OUT_WIDTH = 16;
  localparam int unsigned EDGES     = 8192;

  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned FIN_W   = $clog2(IN_WIDTH);
  localparam int unsigned FOUT_W  = $clog2(OUT_WIDTH);
  localparam int unsigned EDGE_W  = $clog2(EDGES);
  localparam int unsigned RP_W    = $clog2(NODES + 1);
  localparam int unsigned PTR_W   = 14;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned AGG_W   = 40;
  localparam int unsigned PROD_W  = AGG_W + VAL_W;
  localparam int unsigned ACC_W   = PROD_W + FIN_W + 1;
  localparam int unsigned RES_W   = 15;

  typedef enum logic [2:0] {
    OP_LOAD_FEAT = 3'd0,
    OP_LOAD_WGT  = 3'd1,
    OP_LOAD_EDGE = 3'd2,
    OP_LOAD_RP   = 3'd3,
    OP_COMPUTE   = 3'd4
  } op_e;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_RP_A    = 9'b000000010,
    ST_RP_B    = 9'b000000100,
    ST_EDGE_RD = 9'b000001000,
    ST_FEAT    = 9'b000010000,
    ST_FDRAIN  = 9'b000100000,
    ST_DNS     = 9'b001000000,
    ST_DDRAIN  = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_e;

endpackage

// ===== rtl/gcn_layer_csr_aggregate_dense_relu.sv =====
// Top level: graph convolution layer with CSR aggregation, dense product and ReLU.
//
// Usage: input beats on s_axis_* carry loads and compute requests. Loads
// (feature, weight, edge, row pointer) are written in the cycle the beat is
// accepted. A compute beat names a node; the block reads the node's two row
// pointers, walks each edge of the node and accumulates the weighted
// neighbor feature row into an on-chip aggregate row (one feature a cycle),
// then multiplies that row by the weight matrix, one output feature at a
// time, and emits OUT_WIDTH result beats on m_axis_*, the last with tlast.
// The edge phase reads the feature memory and updates the aggregate memory;
// the dense phase reads the weight memory and uses one multiplier. One item
// is worked on at a time; s_axis_tready is high only while the block waits
// for a new item.
// Results leave through an output register: a stalled receiver holds the
// beat and stops the dense sequencer until the beat is taken.
// Reset clears the control state only; stores hold whatever they last held
// and must be loaded before use.
module gcn_layer_csr_aggregate_dense_relu
  import gcn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [15:3] position, [21:16] column, [31:22] neighbor,
  // [45:32] offset, [61:46] value, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] result_value, [24:15] result_node, [28:25] result_feature,
  // [31:29] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  // input fields
  logic [2:0]              in_op;
  logic [12:0]             in_pos;
  logic [5:0]              in_col;
  logic [9:0]              in_nb;
  logic [PTR_W-1:0]        in_off;
  logic signed [VAL_W-1:0] in_val;
  logic                    in_fire;

  assign in_op   = s_axis_tdata[2:0];
  assign in_pos  = s_axis_tdata[15:3];
  assign in_col  = s_axis_tdata[21:16];
  assign in_nb   = s_axis_tdata[31:22];
  assign in_off  = s_axis_tdata[45:32];
  assign in_val  = s_axis_tdata[61:46];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // memories
  logic signed [VAL_W-1:0] feat_mem [NODES*IN_WIDTH];
  logic signed [VAL_W-1:0] wgt_mem  [IN_WIDTH*OUT_WIDTH];
  logic [VAL_W+NODE_W-1:0] edge_mem [EDGES];
  logic [PTR_W-1:0]        rp_mem   [NODES+1];
  logic signed [AGG_W-1:0] agg_mem  [IN_WIDTH];

  logic signed [VAL_W-1:0] feat_rd_q, wgt_rd_q;
  logic [VAL_W+NODE_W-1:0] edge_rd_q;
  logic [PTR_W-1:0]        rp_rd_q;
  logic signed [AGG_W-1:0] agg_rd_q;

  // control
  state_e               state_q, state_d;
  logic [NODE_W-1:0]    node_q, node_d;
  logic [PTR_W-1:0]     k_q, k_d, end_q, end_d;
  logic [FIN_W-1:0]     f_q, f_d;
  logic [FOUT_W-1:0]    o_q, o_d;
  logic                 first_q, first_d;
  logic [RP_W-1:0]      rp_addr;

  // edge pipeline stage
  logic                    p1_v_q;
  logic [FIN_W-1:0]        p1_f_q;
  logic signed [VAL_W-1:0] p1_w_q;
  logic                    p1_first_q;

  // dense pipeline stages
  logic                     d1_v_q, d2_v_q;
  logic signed [AGG_W-1:0]  dns_agg;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_clr;

  // output register
  logic              out_v_q;
  logic [RES_W-1:0]  out_val_q;
  logic [NODE_W-1:0] out_node_q;
  logic [FOUT_W-1:0] out_feat_q;
  logic              out_last_q;
  logic              out_load;

  logic [PTR_W-1:0]        rp_end_clip;
  logic                    feat_issue, dns_issue;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_EMIT) && (!out_v_q || m_axis_tready);
  assign feat_issue    = (state_q == ST_FEAT);
  assign dns_issue     = (state_q == ST_DNS);
  assign rp_end_clip   = (rp_rd_q > PTR_W'(EDGES)) ? PTR_W'(EDGES) : rp_rd_q;

  always_comb begin
    rp_addr = RP_W'(node_q) + RP_W'(1);
    if (state_q == ST_IDLE) begin
      rp_addr = in_pos[RP_W-1:0];
    end
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (in_fire && in_op == OP_LOAD_FEAT && in_pos < 13'(NODES)) begin
      feat_mem[{in_pos[NODE_W-1:0], in_col[FIN_W-1:0]}] <= in_val;
    end
    feat_rd_q <= feat_mem[{edge_rd_q[NODE_W-1:0], f_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_op == OP_LOAD_WGT && in_pos < 13'(IN_WIDTH)
        && in_col < 6'(OUT_WIDTH)) begin
      wgt_mem[{in_pos[FIN_W-1:0], in_col[FOUT_W-1:0]}] <= in_val;
    end
    wgt_rd_q <= wgt_mem[{f_q, o_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_op == OP_LOAD_EDGE) begin
      edge_mem[in_pos[EDGE_W-1:0]] <= {in_val, in_nb};
    end
    edge_rd_q <= edge_mem[k_q[EDGE_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_op == OP_LOAD_RP && in_pos <= 13'(NODES)) begin
      rp_mem[rp_addr] <= in_off;
    end
    rp_rd_q <= rp_mem[rp_addr];
  end

  // Aggregate update: the first edge writes its product, later edges add.
  logic signed [2*VAL_W-1:0] edge_prod;
  logic signed [AGG_W:0]     agg_sum;
  logic signed [AGG_W-1:0]   agg_new;

  always_comb begin
    edge_prod = (p1_w_q * feat_rd_q) >>> 8;
    agg_sum   = (p1_first_q ? '0 : (AGG_W+1)'(agg_rd_q)) + (AGG_W+1)'(edge_prod);
    agg_new   = agg_sum[AGG_W-1:0];
    if (agg_sum[AGG_W] != agg_sum[AGG_W-1]) begin
      agg_new = agg_sum[AGG_W] ? {1'b1, {(AGG_W-1){1'b0}}} : {1'b0, {(AGG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      agg_mem[p1_f_q] <= agg_new;
    end
    agg_rd_q <= agg_mem[f_q];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    node_d  = node_q;
    k_d     = k_q;
    end_d   = end_q;
    f_d     = f_q;
    o_d     = o_q;
    first_d = first_q;
    acc_clr = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_op == OP_COMPUTE && in_pos < 13'(NODES)) begin
          node_d  = in_pos[NODE_W-1:0];
          first_d = 1'b1;
          state_d = ST_RP_A;
        end
      end
      ST_RP_A: begin
        k_d     = rp_rd_q;
        state_d = ST_RP_B;
      end
      ST_RP_B: begin
        end_d   = rp_end_clip;
        f_d     = '0;
        o_d     = '0;
        if (k_q < rp_end_clip) begin
          state_d = ST_EDGE_RD;
        end else begin
          acc_clr = 1'b1;
          state_d = ST_DNS;
        end
      end
      ST_EDGE_RD: begin
        state_d = ST_FEAT;
      end
      ST_FEAT: begin
        f_d = f_q + FIN_W'(1);
        if (f_q == FIN_W'(IN_WIDTH - 1)) begin
          first_d = 1'b0;
          k_d     = k_q + PTR_W'(1);
          state_d = (k_q + PTR_W'(1) < end_q) ? ST_EDGE_RD : ST_FDRAIN;
        end
      end
      ST_FDRAIN: begin
        acc_clr = 1'b1;
        f_d     = '0;
        state_d = ST_DNS;
      end
      ST_DNS: begin
        f_d = f_q + FIN_W'(1);
        if (f_q == FIN_W'(IN_WIDTH - 1)) begin
          state_d = ST_DDRAIN;
        end
      end
      ST_DDRAIN: begin
        if (!d1_v_q && !d2_v_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (o_q == FOUT_W'(OUT_WIDTH - 1)) begin
            state_d = ST_IDLE;
          end else begin
            o_d     = o_q + FOUT_W'(1);
            f_d     = '0;
            acc_clr = 1'b1;
            state_d = ST_DNS;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p1_v_q  <= 1'b0;
      d1_v_q  <= 1'b0;
      d2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      first_q <= 1'b1;
      f_q     <= '0;
      o_q     <= '0;
      k_q     <= '0;
      end_q   <= '0;
      node_q  <= '0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      k_q     <= k_d;
      end_q   <= end_d;
      f_q     <= f_d;
      o_q     <= o_d;
      first_q <= first_d;
      p1_v_q  <= feat_issue;
      d1_v_q  <= dns_issue;
      d2_v_q  <= d1_v_q;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // no edge contributed: aggregate row reads as zero
  assign dns_agg = first_q ? '0 : agg_rd_q;

  // Datapath registers; hold the edge weight with its feature index.
  always_ff @(posedge clk_i) begin
    p1_f_q     <= f_q;
    p1_w_q     <= edge_rd_q[VAL_W+NODE_W-1:NODE_W];
    p1_first_q <= first_q;
    prod_q     <= dns_agg * wgt_rd_q;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (d2_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Drop eight fraction bits, clip at zero and saturate to unsigned Q7.8.
  logic signed [ACC_W-1:0] acc_sh;
  logic [RES_W-1:0]        res_val;

  always_comb begin
    acc_sh = acc_q >>> 8;
    if (acc_sh < 0) begin
      res_val = '0;
    end else if (acc_sh > ACC_W'(32767)) begin
      res_val = '1;
    end else begin
      res_val = acc_sh[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= res_val;
      out_node_q <= node_q;
      out_feat_q <= o_q;
      out_last_q <= (o_q == FOUT_W'(OUT_WIDTH - 1));
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_feat_q, out_node_q, out_val_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_last_feat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> out_feat_q == FOUT_W'(OUT_WIDTH - 1))
    else $error("tlast on a feature other than the final one");

  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EDGE_RD |-> k_q < end_q && end_q <= PTR_W'(EDGES))
    else $error("edge walk outside the row range");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !d1_v_q && !d2_v_q && !p1_v_q)
    else $error("result taken before the dense pipeline drained");
`endif

endmodule
